// ===== rtl/post_wait_match_table_assert.svh =====
// Assertion helpers used by the RTL controller of the post/wait match table.
`ifndef POST_WAIT_MATCH_TABLE_ASSERT_SVH
`define POST_WAIT_MATCH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PWMT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pwmt assertion failed");

// Next-cycle implication, disabled during reset.
`define PWMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pwmt assertion failed");

`endif

// ===== rtl/pwmt_pkg.sv =====
package pwmt_pkg;

  localparam int NODE_W        = 16;
  localparam int TAG_W         = 32;
  localparam int STATUS_W      = 3;
  localparam int OP_W          = 3;
  localparam int DEFAULT_DEPTH = 32;
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;

  // Register index of own_rank.
  localparam logic REG_OWN_RANK = 1'b0;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_POST      = 3'd0;
  localparam logic [OP_W-1:0] OP_ARRIVE    = 3'd1;
  localparam logic [OP_W-1:0] OP_WAIT_ANY  = 3'd2;
  localparam logic [OP_W-1:0] OP_WAIT_NODE = 3'd3;
  localparam logic [OP_W-1:0] OP_WAIT_BOTH = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_STORED   = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FORWARD  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_MET      = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_PENDING  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_PEND_MET = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_REJECT   = 3'd6;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_ANY  = 2'd1,
    MODE_NODE = 2'd2,
    MODE_BOTH = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   node;
    logic [TAG_W-1:0]    tag;
  } res_t;

  function automatic logic match(mode_t mode, logic [NODE_W-1:0] want_node,
                                 logic [TAG_W-1:0] want_tag,
                                 logic [NODE_W-1:0] node, logic [TAG_W-1:0] tag);
    logic hit;
    case (mode)
      MODE_ANY:  hit = 1'b1;
      MODE_NODE: hit = (node == want_node);
      MODE_BOTH: hit = (node == want_node) && (tag == want_tag);
      default:   hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ===== rtl/pwmt_mem.sv =====
module pwmt_mem #(
  parameter int DEPTH = pwmt_pkg::DEFAULT_DEPTH,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = pwmt_pkg::NODE_W + pwmt_pkg::TAG_W
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/pwmt_ctrl.sv =====
module pwmt_ctrl #(
  parameter int TABLE_DEPTH = pwmt_pkg::DEFAULT_DEPTH,
  parameter int AW          = $clog2(TABLE_DEPTH),
  parameter int CW          = $clog2(TABLE_DEPTH + 1),
  parameter int DW          = pwmt_pkg::NODE_W + pwmt_pkg::TAG_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [pwmt_pkg::NODE_W-1:0]  own_rank,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [pwmt_pkg::OP_W-1:0]    operation,
  input  logic [pwmt_pkg::NODE_W-1:0]  node_id,
  input  logic [pwmt_pkg::TAG_W-1:0]   tag_value,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output pwmt_pkg::res_t               rsp,
  output logic [CW-1:0]                rsp_count,
  output logic                         rd_en,
  output logic [AW-1:0]                rd_addr,
  input  logic [DW-1:0]                rd_data,
  output logic                         wr_en,
  output logic [AW-1:0]                wr_addr,
  output logic [DW-1:0]                wr_data
);

  pwmt_pkg::state_t state, state_next;
  logic [CW-1:0]    count, count_next;
  pwmt_pkg::mode_t  pmode, pmode_next;
  logic [pwmt_pkg::NODE_W-1:0] pnode, pnode_next;
  logic [pwmt_pkg::TAG_W-1:0]  ptag, ptag_next;
  pwmt_pkg::mode_t  wmode, wmode_next;
  logic [pwmt_pkg::NODE_W-1:0] wnode, wnode_next;
  logic [pwmt_pkg::TAG_W-1:0]  wtag, wtag_next;
  logic [AW-1:0]    idx, idx_next;
  pwmt_pkg::res_t   res, res_next;
  logic             rsp_valid_next;
  pwmt_pkg::res_t   rsp_next;
  logic [CW-1:0]    rsp_count_next;

  logic [pwmt_pkg::NODE_W-1:0] rd_node;
  logic [pwmt_pkg::TAG_W-1:0]  rd_tag;
  logic                        more;
  logic                        full;

  assign rd_node = rd_data[DW-1 -: pwmt_pkg::NODE_W];
  assign rd_tag  = rd_data[pwmt_pkg::TAG_W-1:0];
  assign more    = (CW'(idx) + CW'(1)) < count;
  assign full    = (count == CW'(TABLE_DEPTH));

  assign req_stall = (state != pwmt_pkg::S_IDLE);

  always_comb begin
    state_next     = state;
    count_next     = count;
    pmode_next     = pmode;
    pnode_next     = pnode;
    ptag_next      = ptag;
    wmode_next     = wmode;
    wnode_next     = wnode;
    wtag_next      = wtag;
    idx_next       = idx;
    res_next       = res;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    rsp_count_next = rsp_count;
    rd_en          = 1'b0;
    rd_addr        = idx;
    wr_en          = 1'b0;
    wr_addr        = AW'(count);
    wr_data        = {node_id, tag_value};

    case (state)
      pwmt_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = pwmt_pkg::S_DONE;
          res_next   = '{pwmt_pkg::STAT_REJECT, '0, '0};
          case (operation)
            pwmt_pkg::OP_POST: begin
              if (node_id == own_rank) begin
                wr_data = {own_rank, tag_value};
                if (full) begin
                  res_next.status = pwmt_pkg::STAT_FULL;
                end else begin
                  wr_en           = 1'b1;
                  count_next      = count + CW'(1);
                  res_next.status = pwmt_pkg::STAT_STORED;
                end
              end else begin
                res_next = '{pwmt_pkg::STAT_FORWARD, node_id, tag_value};
              end
            end
            pwmt_pkg::OP_ARRIVE: begin
              if (pmode != pwmt_pkg::MODE_NONE &&
                  pwmt_pkg::match(pmode, pnode, ptag, node_id, tag_value)) begin
                pmode_next      = pwmt_pkg::MODE_NONE;
                pnode_next      = '0;
                ptag_next       = '0;
                res_next.status = pwmt_pkg::STAT_PEND_MET;
              end else if (full) begin
                res_next.status = pwmt_pkg::STAT_FULL;
              end else begin
                wr_en           = 1'b1;
                count_next      = count + CW'(1);
                res_next.status = pwmt_pkg::STAT_STORED;
              end
            end
            pwmt_pkg::OP_WAIT_ANY, pwmt_pkg::OP_WAIT_NODE, pwmt_pkg::OP_WAIT_BOTH: begin
              case (operation)
                pwmt_pkg::OP_WAIT_ANY:  wmode_next = pwmt_pkg::MODE_ANY;
                pwmt_pkg::OP_WAIT_NODE: wmode_next = pwmt_pkg::MODE_NODE;
                default:                wmode_next = pwmt_pkg::MODE_BOTH;
              endcase
              wnode_next = node_id;
              wtag_next  = tag_value;
              if (pmode != pwmt_pkg::MODE_NONE) begin
                res_next.status = pwmt_pkg::STAT_REJECT;
              end else if (count == '0) begin
                pmode_next = wmode_next;
                pnode_next = (wmode_next == pwmt_pkg::MODE_ANY) ? '0 : node_id;
                ptag_next  = (wmode_next == pwmt_pkg::MODE_BOTH) ? tag_value : '0;
                res_next.status = pwmt_pkg::STAT_PENDING;
              end else begin
                // Start the newest-first scan at the top entry.
                rd_en      = 1'b1;
                rd_addr    = AW'(count - CW'(1));
                idx_next   = rd_addr;
                state_next = pwmt_pkg::S_SEARCH;
              end
            end
            default: begin
              res_next.status = pwmt_pkg::STAT_REJECT;
            end
          endcase
        end
      end
      pwmt_pkg::S_SEARCH: begin
        // rd_data holds entry idx.
        if (pwmt_pkg::match(wmode, wnode, wtag, rd_node, rd_tag)) begin
          res_next = '{pwmt_pkg::STAT_MET, '0, '0};
          if (more) begin
            rd_en      = 1'b1;
            rd_addr    = idx + AW'(1);
            idx_next   = rd_addr;
            state_next = pwmt_pkg::S_SHIFT;
          end else begin
            count_next = count - CW'(1);
            state_next = pwmt_pkg::S_DONE;
          end
        end else if (idx == '0) begin
          pmode_next = wmode;
          pnode_next = (wmode == pwmt_pkg::MODE_ANY) ? '0 : wnode;
          ptag_next  = (wmode == pwmt_pkg::MODE_BOTH) ? wtag : '0;
          res_next   = '{pwmt_pkg::STAT_PENDING, '0, '0};
          state_next = pwmt_pkg::S_DONE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = idx - AW'(1);
          idx_next = rd_addr;
        end
      end
      pwmt_pkg::S_SHIFT: begin
        // Move entry idx down one slot while fetching the next one up.
        wr_en   = 1'b1;
        wr_addr = idx - AW'(1);
        wr_data = rd_data;
        if (more) begin
          rd_en    = 1'b1;
          rd_addr  = idx + AW'(1);
          idx_next = rd_addr;
        end else begin
          count_next = count - CW'(1);
          state_next = pwmt_pkg::S_DONE;
        end
      end
      pwmt_pkg::S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next = 1'b1;
          rsp_next       = res;
          rsp_count_next = count;
          state_next     = pwmt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pwmt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pwmt_pkg::S_IDLE;
      count     <= '0;
      pmode     <= pwmt_pkg::MODE_NONE;
      pnode     <= '0;
      ptag      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      pmode     <= pmode_next;
      pnode     <= pnode_next;
      ptag      <= ptag_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    wmode     <= wmode_next;
    wnode     <= wnode_next;
    wtag      <= wtag_next;
    idx       <= idx_next;
    res       <= res_next;
    rsp       <= rsp_next;
    rsp_count <= rsp_count_next;
  end

`include "post_wait_match_table_assert.svh"

  `PWMT_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CW'(TABLE_DEPTH))
  `PWMT_ASSERT_IMPL(a_shift_in_range, clk, rst, state == pwmt_pkg::S_SHIFT, CW'(idx) < count)
  `PWMT_ASSERT_NEXT(a_accept_busy, clk, rst, req_valid && !req_stall, state != pwmt_pkg::S_IDLE)
  `PWMT_ASSERT_IMPL(a_pending_set, clk, rst,
    state == pwmt_pkg::S_DONE && res.status == pwmt_pkg::STAT_PENDING,
    pmode != pwmt_pkg::MODE_NONE)

endmodule

// ===== rtl/post_wait_match_table.sv =====
// Post/wait match table.
// Request channel (req_valid/req_stall) carries one word per operation:
// operation, node_id, tag_value. A word is taken when req_valid is high and
// req_stall is low. Result channel (rsp_valid/rsp_stall) returns exactly one
// word per request: status, send_node, send_tag, entry_count.
// A wait that scans the table reads its entries one at a time, newest first,
// out of a single-port-read table memory; a hit then compacts the younger
// entries at one entry per cycle through the same memory.
// One request is in flight at a time; req_stall is high while it is worked.
// The finished word sits in an output register, so the next request is
// taken while rsp_stall holds the previous result.
// Reset clears the entry count, the pending wait and own_rank; table
// contents need no clearing since only entries below the count are read.
// The user must write own_rank over the APB port only while the block is idle; the block does not enforce this.
module post_wait_match_table #(
  parameter int TABLE_DEPTH = pwmt_pkg::DEFAULT_DEPTH,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int CW = $clog2(TABLE_DEPTH + 1),
  localparam int DW = pwmt_pkg::NODE_W + pwmt_pkg::TAG_W
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pwmt_pkg::APB_AW-1:0]         paddr,
  input  logic [pwmt_pkg::APB_DW-1:0]         pwdata,
  output logic [pwmt_pkg::APB_DW-1:0]         prdata,
  output logic                                pready,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [pwmt_pkg::OP_W-1:0]           operation,
  input  logic [pwmt_pkg::NODE_W-1:0]         node_id,
  input  logic signed [pwmt_pkg::TAG_W-1:0]   tag_value,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [pwmt_pkg::STATUS_W-1:0]       status,
  output logic [pwmt_pkg::NODE_W-1:0]         send_node,
  output logic signed [pwmt_pkg::TAG_W-1:0]   send_tag,
  output logic [CW-1:0]                       entry_count
);

  logic [pwmt_pkg::NODE_W-1:0] own_rank;
  logic                        reg_sel;
  pwmt_pkg::res_t              rsp;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  // Register index is the word address; only own_rank exists.
  assign reg_sel = (paddr[2] == pwmt_pkg::REG_OWN_RANK);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(pwmt_pkg::APB_DW - pwmt_pkg::NODE_W){1'b0}}, own_rank} : '0;

  // Write on the access phase; drop writes to unmapped words.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_rank <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      own_rank <= pwdata[pwmt_pkg::NODE_W-1:0];
    end
  end

  assign status    = rsp.status;
  assign send_node = rsp.node;
  assign send_tag  = rsp.tag;

  pwmt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW),
    .DW          (DW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .own_rank  (own_rank),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .operation (operation),
    .node_id   (node_id),
    .tag_value (tag_value),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .rsp_count (entry_count),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  pwmt_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule
